// File: rtl/ksr_pkg.sv
// ksr_pkg: shared types and constants for the group stream reverser.
// No dependencies; imported by the interfaces and all modules.
package ksr_pkg;

   localparam int KSR_MAX_GROUP = 16;
   localparam int VALUE_W       = 32;
   localparam int GSIZE_W       = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [GSIZE_W-1:0]        gsize_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_FILL = 2'd0,
      ST_REV  = 2'd1,
      ST_FWD  = 2'd2
   } state_type;

endpackage

// File: rtl/ksr_req_if.sv
// ksr_req_if: input channel, valid/ready plus one sequence element.
// Depends on ksr_pkg.
interface ksr_req_if;
   logic               valid;
   logic               ready;
   ksr_pkg::value_type value;
   logic               end_of_list;

   modport source (output valid, output value, output end_of_list, input ready);
   modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

// File: rtl/ksr_rsp_if.sv
// ksr_rsp_if: result channel, valid/ready plus one reordered element.
// Depends on ksr_pkg.
interface ksr_rsp_if;
   logic               valid;
   logic               ready;
   ksr_pkg::value_type value_out;
   logic               last_of_burst;
   logic               list_done;

   modport source (output valid, output value_out, output last_of_burst,
                   output list_done, input ready);
   modport sink   (input valid, input value_out, input last_of_burst,
                   input list_done, output ready);
endinterface

// File: rtl/ksr_cell.sv
// ksr_cell: one storage cell of the group buffer chain; shifts right on push,
// left on pop. Depends on ksr_pkg.
module ksr_cell (
   input  logic                 clock,
   input  ksr_pkg::cell_op_type op,
   input  ksr_pkg::value_type   left_data,
   input  ksr_pkg::value_type   right_data,
   output ksr_pkg::value_type   data_out
);
   import ksr_pkg::*;

   value_type data_ff;

   always_ff @(posedge clock) begin
      unique case (op)
         CELL_HOLD: data_ff <= data_ff;
         CELL_PUSH: data_ff <= left_data;
         CELL_POP:  data_ff <= right_data;
         default:   data_ff <= data_ff;
      endcase
   end

   assign data_out = data_ff;
endmodule

// File: rtl/k_group_stream_reverser_unit.sv
// k_group_stream_reverser_unit: top level, reverses a value stream in full groups.
// Depends on ksr_pkg, ksr_req_if, ksr_rsp_if and ksr_cell.
//
// Usage:
//   req_chan carries one signed value per transaction plus an end_of_list flag.
//   rsp_chan returns the reordered values; last_of_burst marks the final result
//   caused by one input transaction, list_done the final result of the list.
//   csr_write_enable/csr_write_data set the group size (0 acts as 1, values
//   above MAX_GROUP act as MAX_GROUP); write it only while the block is idle.
// Timing:
//   Values are pushed into a chain of MAX_GROUP cells, one per cycle. A full
//   group drains in reverse order, a partial one closed by end_of_list in
//   input order, one result per cycle through the output register; no input
//   is taken during the drain, so a new item waits until the group has left.
//   The first result is registered after the state register turns to drain.
// Reset clears the fill count, the drain state, the output valid and sets the
//   group size to 1. When rsp_chan stalls, the drain holds and the output
//   register keeps its result.
module k_group_stream_reverser_unit #(
   parameter int MAX_GROUP = ksr_pkg::KSR_MAX_GROUP
) (
   input  logic                clock,
   input  logic                reset,
   ksr_req_if.sink             req_chan,
   ksr_rsp_if.source           rsp_chan,
   input  logic                csr_write_enable,
   input  ksr_pkg::gsize_type  csr_write_data
);
   import ksr_pkg::*;

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CMP_W = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

   gsize_type          gsize_ff;
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               eol_ff, eol_in;
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;

   cell_op_type        cell_op;
   value_type          cell_data [MAX_GROUP];
   logic [CMP_W-1:0]   gsize_ext, k_eff, n_ext;
   logic [CNT_W-1:0]   count_p1, count_m1;
   logic [IDX_W-1:0]   rd_idx;
   logic               accept, out_free, last_one;

   // group buffer chain
   for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
      value_type left_d, right_d;
      if (i == 0) begin : g_head
         assign left_d = req_chan.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == MAX_GROUP - 1) begin : g_tail
         assign right_d = '0;
      end else begin : g_body
         assign right_d = cell_data[i+1];
      end
      ksr_cell u_cell (
         .clock      (clock),
         .op         (cell_op),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= GSIZE_W'(1);
      end else if (csr_write_enable) begin
         gsize_ff <= csr_write_data;
      end
   end

   assign gsize_ext = CMP_W'(gsize_ff);
   always_comb begin
      if (gsize_ff == '0) begin
         k_eff = CMP_W'(1);
      end else if (gsize_ext > CMP_W'(MAX_GROUP)) begin
         k_eff = CMP_W'(MAX_GROUP);
      end else begin
         k_eff = gsize_ext;
      end
   end

   assign count_p1 = count_ff + CNT_W'(1);
   assign count_m1 = count_ff - CNT_W'(1);
   assign n_ext    = CMP_W'(count_p1);
   assign rd_idx   = count_m1[IDX_W-1:0];
   assign last_one = (count_ff == CNT_W'(1));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign req_chan.ready = (state_ff == ST_FILL);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      eol_in       = eol_ff;
      cell_op      = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_chan.valid) begin
               cell_op  = CELL_PUSH;
               count_in = count_p1;
               eol_in   = req_chan.end_of_list;
               if (n_ext >= k_eff) begin
                  state_in = ST_REV;
               end else if (req_chan.end_of_list) begin
                  state_in = ST_FWD;
               end
            end
         end
         ST_REV: begin
            if (out_free) begin
               cell_op      = CELL_POP;
               count_in     = count_m1;
               rsp_valid_in = 1'b1;
               rsp_value_in = cell_data[0];
               rsp_last_in  = last_one;
               rsp_done_in  = last_one && eol_ff;
               if (last_one) state_in = ST_FILL;
            end
         end
         ST_FWD: begin
            if (out_free) begin
               count_in     = count_m1;
               rsp_valid_in = 1'b1;
               rsp_value_in = cell_data[rd_idx];
               rsp_last_in  = last_one;
               rsp_done_in  = last_one;
               if (last_one) state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         eol_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         eol_ff       <= eol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.value_out     = rsp_value_ff;
   assign rsp_chan.last_of_burst = rsp_last_ff;
   assign rsp_chan.list_done     = rsp_done_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_GROUP))
      else $error("fill count beyond buffer depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV || state_ff == ST_FWD) |-> (count_ff != '0))
      else $error("drain with empty buffer");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_p1)))
      else $error("fill count not advanced on transaction");

endmodule
